// ----- sv/pgeg_pkg.sv -----
// Shared types and constants for the periodic grain envelope gate.
package pgeg_pkg;

   // Tick counter and grain countdown width.
   localparam int TICK_BITS = 16;

   // Configuration register widths.
   localparam int LENGTH_BITS = 16;
   localparam int RATE_BITS   = 7;
   localparam int RAMP_BITS   = 12;

   // Configuration write channel.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   // Envelope gain: unsigned, ENV_ONE stands for unity.
   localparam int ENV_BITS = 17;
   localparam logic [ENV_BITS-1:0] ENV_ONE = 17'h10000;

   // Shared divider: quotient bits, bits retired per cycle, iteration count and its counter width.
   localparam int DIV_BITS     = 16;
   localparam int DIV_STEP     = 2;
   localparam int DIV_CYCLES   = DIV_BITS / DIV_STEP;
   localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GRAIN_LENGTH = 4'd0,
      REG_TRIGGER_RATE = 4'd1,
      REG_ATTACK_LEN   = 4'd2,
      REG_DECAY_LEN    = 4'd3
   } reg_index_type;

   // Request to the divider: the quotient is (rem_init:dividend) / divisor.
   // rem_init must be below divisor so that the quotient fits DIV_BITS.
   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] rem_init;
      logic [DIV_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_req_type;

   // Divider answer, valid in the cycle that done is high.
   typedef struct packed {
      logic                done;
      logic                busy;
      logic [DIV_BITS-1:0] quotient;
      logic [DIV_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- sv/pgeg_div.sv -----
// Shared radix-4 restoring divider for the trigger period, phase and envelope.
module pgeg_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pgeg_pkg::div_req_type req,
   output pgeg_pkg::div_rsp_type rsp
);
   import pgeg_pkg::*;

   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     dvd_ff, dvd_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_BITS-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [DIV_BITS-1:0]     rem_v, dvd_v, quo_v;
   logic [DIV_BITS:0]       trial;

   // Two compare-and-subtract steps per cycle on the partial remainder.
   always_comb begin
      rem_v = rem_ff;
      dvd_v = dvd_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem_v, dvd_v[DIV_BITS-1]};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_v = DIV_BITS'(trial - {1'b0, divisor_ff});
            quo_v = {quo_v[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_v = trial[DIV_BITS-1:0];
            quo_v = {quo_v[DIV_BITS-2:0], 1'b0};
         end
         dvd_v = {dvd_v[DIV_BITS-2:0], 1'b0};
      end
   end

   // Load on start, then iterate, counting steps, until the last step raises done.
   always_comb begin
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = req.rem_init;
         dvd_in     = req.dividend;
         quo_in     = '0;
         divisor_in = req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_v;
         dvd_in = dvd_v;
         quo_in = quo_v;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.busy      = busy_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   // A new division is never started on top of one in progress.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider restarted while busy");

   // A finished division leaves a remainder below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   // Completion is a single-cycle pulse.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
`endif

endmodule

// ----- sv/pgeg_lane.sv -----
// One channel lane: sample times envelope gain, floored back to sample width.
module pgeg_lane #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic signed [SAMPLE_BITS-1:0]        sample,
   input  logic        [pgeg_pkg::ENV_BITS-1:0] env,
   output logic signed [SAMPLE_BITS-1:0]        scaled
);
   import pgeg_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + ENV_BITS + 1;

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   // Signed by unsigned multiply; the gain is widened with a zero sign bit and both
   // operands are extended to the full product width first.
   assign prod_in = PROD_BITS'(sample) * PROD_BITS'($signed({1'b0, env}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Arithmetic shift by the gain's fraction bits floors toward minus infinity.
   assign scaled = prod_ff[SAMPLE_BITS+ENV_BITS-2:ENV_BITS-1];

endmodule

// ----- sv/periodic_grain_envelope_gate.sv -----
// Top level: trigger timing, grain countdown, envelope sequencing and output merge.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: left_in, right_in
//   rsp      out        rsp_tvalid/rsp_tready  tdata: left_out, right_out; tuser: grain_active
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item at a time runs from acceptance to a waiting result through these steps:
// period and phase passes of the shared divider when triggering is on, the update,
// an envelope gain pass on a ramp, the multiply and the merge. The next item can be
// taken in the cycle after the merge. A finished result sits in the output register
// while the next item is accepted. Reset is synchronous and clears configuration,
// tick counter, grain countdown and handshake state. A stalled result holds the
// sequencer in its last step until the output register frees. Configuration writes
// are always taken.
module periodic_grain_envelope_gate #(
   parameter int FRAME_RATE  = 44100,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // left_in, right_in
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // left_out, right_out
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // grain_active
   output logic [0:0]                             rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [pgeg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pgeg_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready
);
   import pgeg_pkg::*;

   localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;
   localparam logic [TICK_BITS-1:0] FRAME_LAST = TICK_BITS'(FRAME_RATE - 1);
   localparam logic [DIV_BITS-1:0]  FRAME_VAL  = DIV_BITS'(FRAME_RATE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PERIOD,
      ST_MODULO,
      ST_UPDATE,
      ST_ENV,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [LENGTH_BITS-1:0]         grain_length_ff, grain_length_in;
   logic [RATE_BITS-1:0]           trigger_rate_ff, trigger_rate_in;
   logic [RAMP_BITS-1:0]           attack_len_ff, attack_len_in;
   logic [RAMP_BITS-1:0]           decay_len_ff, decay_len_in;
   logic [TICK_BITS-1:0]           tick_ff, tick_in;
   logic [TICK_BITS-1:0]           tick_now_ff, tick_now_in;
   logic [TICK_BITS-1:0]           remaining_ff, remaining_in;
   logic                           fire_ff, fire_in;
   logic                           active_ff, active_in;
   logic [ENV_BITS-1:0]            env_ff, env_in;
   logic signed [SAMPLE_BITS-1:0]  left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0]  right_ff, right_in;
   logic signed [SAMPLE_BITS-1:0]  rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0]  rsp_right_ff, rsp_right_in;
   logic                           rsp_active_ff, rsp_active_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   div_req_type                    div_req_ff, div_req_in;
   div_rsp_type                    div_rsp;

   logic signed [SAMPLE_BITS-1:0]  left_scaled, right_scaled;
   logic [TICK_BITS-1:0]           tick_wrap;
   logic [DIV_BITS-1:0]            period;
   logic [TICK_BITS-1:0]           rem_next;
   logic [TICK_BITS-1:0]           r_val;
   logic [TICK_BITS-1:0]           decay_wide;
   logic                           full_level;
   logic                           use_attack;
   logic                           use_decay;
   logic                           req_fire;
   logic                           rsp_fire;
   logic                           rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid_ff && rsp_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // Tick counter folds back to zero once it passes the last tick of a frame.
   assign tick_wrap = (tick_ff > FRAME_LAST) ? '0 : tick_ff;

   // A rate above the frame rate gives a zero period, which triggers every tick.
   assign period = (div_rsp.quotient == '0) ? DIV_BITS'(1) : div_rsp.quotient;

   // Countdown after an optional reload, and the envelope region it falls in.
   assign rem_next   = fire_ff ? grain_length_ff : remaining_ff;
   assign r_val      = rem_next - 1'b1;
   assign decay_wide = TICK_BITS'(decay_len_ff);
   assign full_level = (grain_length_ff == '0) || (r_val >= grain_length_ff);
   assign use_attack = r_val < TICK_BITS'(attack_len_ff);
   assign use_decay  = (decay_wide != '0) && (decay_wide <= grain_length_ff) &&
                       (r_val > (grain_length_ff - decay_wide));

   // Sequencer, configuration and output register.
   always_comb begin
      state_in        = state_ff;
      grain_length_in = grain_length_ff;
      trigger_rate_in = trigger_rate_ff;
      attack_len_in   = attack_len_ff;
      decay_len_in    = decay_len_ff;
      tick_in         = tick_ff;
      tick_now_in     = tick_now_ff;
      remaining_in    = remaining_ff;
      fire_in         = fire_ff;
      active_in       = active_ff;
      env_in          = env_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_tvalid_in   = rsp_tvalid_ff;
      div_req_in      = div_req_ff;
      div_req_in.start = 1'b0;

      // Configuration writes.
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_GRAIN_LENGTH: grain_length_in = csr_data[LENGTH_BITS-1:0];
            REG_TRIGGER_RATE: trigger_rate_in = csr_data[RATE_BITS-1:0];
            REG_ATTACK_LEN:   attack_len_in   = csr_data[RAMP_BITS-1:0];
            REG_DECAY_LEN:    decay_len_in    = csr_data[RAMP_BITS-1:0];
            default: ;
         endcase
      end

      // The result leaves when the downstream side takes it.
      if (rsp_fire) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               left_in     = req_tdata[SAMPLE_BITS-1:0];
               right_in    = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
               tick_now_in = tick_wrap;
               tick_in     = tick_wrap + 1'b1;
               fire_in     = 1'b0;
               if (trigger_rate_ff != '0) begin
                  div_req_in.start    = 1'b1;
                  div_req_in.rem_init = '0;
                  div_req_in.dividend = FRAME_VAL;
                  div_req_in.divisor  = DIV_BITS'(trigger_rate_ff);
                  state_in            = ST_PERIOD;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_PERIOD: begin
            if (div_rsp.done) begin
               div_req_in.start    = 1'b1;
               div_req_in.rem_init = '0;
               div_req_in.dividend = tick_now_ff;
               div_req_in.divisor  = period;
               state_in            = ST_MODULO;
            end
         end
         ST_MODULO: begin
            if (div_rsp.done) begin
               fire_in  = (div_rsp.remainder == '0);
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            remaining_in = rem_next;
            active_in    = 1'b0;
            env_in       = '0;
            state_in     = ST_MUL;
            if (rem_next != '0) begin
               remaining_in = r_val;
               active_in    = 1'b1;
               env_in       = ENV_ONE;
               if (full_level) begin
                  env_in = ENV_ONE;
               end else if (use_attack) begin
                  div_req_in.start    = 1'b1;
                  div_req_in.rem_init = r_val;
                  div_req_in.dividend = '0;
                  div_req_in.divisor  = DIV_BITS'(attack_len_ff);
                  state_in            = ST_ENV;
               end else if (use_decay) begin
                  div_req_in.start    = 1'b1;
                  div_req_in.rem_init = grain_length_ff - r_val;
                  div_req_in.dividend = '0;
                  div_req_in.divisor  = DIV_BITS'(decay_len_ff);
                  state_in            = ST_ENV;
               end
            end
         end
         ST_ENV: begin
            if (div_rsp.done) begin
               env_in   = ENV_BITS'(div_rsp.quotient);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Lane products settle into their registers during this cycle.
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Merge both lanes and the gate flag into the output register.
            if (rsp_free) begin
               rsp_left_in   = left_scaled;
               rsp_right_in  = right_scaled;
               rsp_active_in = active_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         grain_length_ff  <= '0;
         trigger_rate_ff  <= '0;
         attack_len_ff    <= '0;
         decay_len_ff     <= '0;
         tick_ff          <= '0;
         remaining_ff     <= '0;
         rsp_tvalid_ff    <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         grain_length_ff  <= grain_length_in;
         trigger_rate_ff  <= trigger_rate_in;
         attack_len_ff    <= attack_len_in;
         decay_len_ff     <= decay_len_in;
         tick_ff          <= tick_in;
         remaining_ff     <= remaining_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
         div_req_ff.start <= div_req_in.start;
      end
      div_req_ff.rem_init <= div_req_in.rem_init;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      tick_now_ff         <= tick_now_in;
      fire_ff             <= fire_in;
      active_ff           <= active_in;
      env_ff              <= env_in;
      left_ff             <= left_in;
      right_ff            <= right_in;
      rsp_left_ff         <= rsp_left_in;
      rsp_right_ff        <= rsp_right_in;
      rsp_active_ff       <= rsp_active_in;
   end

   pgeg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   pgeg_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_left (
      .clock  (clock),
      .sample (left_ff),
      .env    (env_ff),
      .scaled (left_scaled)
   );

   pgeg_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_right (
      .clock  (clock),
      .sample (right_ff),
      .env    (env_ff),
      .scaled (right_scaled)
   );

   assign rsp_tdata  = TDATA_BITS'({rsp_right_ff, rsp_left_ff});
   assign rsp_tuser  = rsp_active_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

`ifndef SYNTHESIS
   // With no grain sounding both channels are silent.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_active_ff) |-> (rsp_left_ff == '0 && rsp_right_ff == '0))
      else $error("output not silent without an active grain");

   // The tick counter never runs past one frame.
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_ff <= TICK_BITS'(FRAME_RATE))
      else $error("tick counter past frame length");

   // The gain handed to the lanes never exceeds unity.
   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (env_ff <= ENV_ONE))
      else $error("envelope gain above unity");

   // Divider answers arrive only while the sequencer waits for one.
   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PERIOD || state_ff == ST_MODULO ||
                        state_ff == ST_ENV))
      else $error("unexpected divider completion");
`endif

endmodule

// ----- verif/periodic_grain_envelope_gate_checker.sv -----
// Channel monitor, grain envelope predictor and result scoreboard for the gate.
module periodic_grain_envelope_gate_checker #(
   parameter int FRAME_RATE  = 44100,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,
   input  logic                                      req_tvalid,
   input  logic                                      req_tready,
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,
   input  logic [0:0]                                rsp_tuser,
   input  logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   input  logic [pgeg_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [pgeg_pkg::CSR_DATA_BITS-1:0]        csr_data,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   output int                                        fail_count,
   output int                                        pending,
   output int                                        results_seen,
   output int                                        gated_seen
);
   import pgeg_pkg::*;

   localparam int SW = SAMPLE_BITS;
   localparam int PRINT_CAP = 30;

   // One expected output sample pair with its gate flag.
   typedef struct packed {
      logic [SW-1:0] left;
      logic [SW-1:0] right;
      logic          active;
   } gated_sample_type;

   // Local copy of the configuration registers.
   logic [LENGTH_BITS-1:0] grain_len;
   logic [RATE_BITS-1:0]   rate;
   logic [RAMP_BITS-1:0]   attack;
   logic [RAMP_BITS-1:0]   decay;

   // Local copy of the tick counter and the grain countdown.
   logic [TICK_BITS-1:0]   tick;
   logic [TICK_BITS-1:0]   countdown;

   gated_sample_type       gated_q[$];

   // Prints one line per mismatch up to a cap, and always counts it.
   task automatic report(input string msg);
      if (fail_count < PRINT_CAP)
         $display("[checker] %0t: %s", $time, msg);
      fail_count++;
   endtask

   // Trapezoid gain for the decremented countdown; ENV_ONE is unity.
   function automatic logic [ENV_BITS-1:0] gain_for(input logic [TICK_BITS-1:0] left_count);
      logic [ENV_BITS-1:0] g;
      g = ENV_ONE;
      if (grain_len != 0 && left_count < grain_len) begin
         if (left_count < attack) begin
            g = ENV_BITS'((64'(left_count) << 16) / 64'(attack));
         end else if (decay != 0 && decay <= grain_len &&
                      left_count > grain_len - LENGTH_BITS'(decay)) begin
            g = ENV_BITS'((64'(grain_len - left_count) << 16) / 64'(decay));
         end
      end
      return g;
   endfunction

   // Sample times gain, rounded toward minus infinity.
   function automatic logic [SW-1:0] scaled(input logic [SW-1:0] s,
                                            input logic [ENV_BITS-1:0] g);
      longint prod;
      prod = longint'($signed(s)) * longint'(g);
      return SW'(prod >>> 16);
   endfunction

   // Advances the trigger timing and countdown by one sample and forms its output.
   function automatic gated_sample_type gate_sample(input logic [SW-1:0] l_in,
                                                    input logic [SW-1:0] r_in);
      gated_sample_type res;
      logic             fire;
      int               period;
      logic [ENV_BITS-1:0] g;
      res  = '0;
      fire = 1'b0;
      if (int'(tick) > FRAME_RATE - 1)
         tick = '0;
      if (rate != 0) begin
         period = FRAME_RATE / int'(rate);
         if (period == 0)
            period = 1;
         fire = (int'(tick) % period) == 0;
      end
      tick = tick + 1'b1;
      if (fire)
         countdown = grain_len;
      if (countdown != 0) begin
         countdown  = countdown - 1'b1;
         g          = gain_for(countdown);
         res.left   = scaled(l_in, g);
         res.right  = scaled(r_in, g);
         res.active = 1'b1;
      end
      return res;
   endfunction

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      gated_sample_type want;
      logic [SW-1:0]    got_left;
      logic [SW-1:0]    got_right;
      if (reset) begin
         grain_len    = '0;
         rate         = '0;
         attack       = '0;
         decay        = '0;
         tick         = '0;
         countdown    = '0;
         gated_q.delete();
         pending      = 0;
         results_seen = 0;
         gated_seen   = 0;
         fail_count   = 0;
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_GRAIN_LENGTH: grain_len = csr_data[LENGTH_BITS-1:0];
               REG_TRIGGER_RATE: rate      = csr_data[RATE_BITS-1:0];
               REG_ATTACK_LEN:   attack    = csr_data[RAMP_BITS-1:0];
               REG_DECAY_LEN:    decay     = csr_data[RAMP_BITS-1:0];
               default: ;
            endcase
         end

         // Input transaction: predict its result.
         if (req_tvalid && req_tready)
            gated_q.push_back(gate_sample(req_tdata[SW-1:0], req_tdata[2*SW-1:SW]));

         // Result transaction: compare with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_left  = rsp_tdata[SW-1:0];
            got_right = rsp_tdata[2*SW-1:SW];
            if (gated_q.size() == 0) begin
               report($sformatf("result with nothing expected: left %h right %h gate %b",
                                got_left, got_right, rsp_tuser[0]));
            end else begin
               want = gated_q.pop_front();
               if (want.active)
                  gated_seen++;
               if (got_left !== want.left)
                  report($sformatf("left_out %h, expected %h", got_left, want.left));
               if (got_right !== want.right)
                  report($sformatf("right_out %h, expected %h", got_right, want.right));
               if (rsp_tuser[0] !== want.active)
                  report($sformatf("grain_active %b, expected %b", rsp_tuser[0],
                                   want.active));
            end
         end
         pending = gated_q.size();
      end
   end

   // Anything still waiting at the end is reported.
   final begin
      if (gated_q.size() != 0)
         $display("[checker] %0d results never arrived", gated_q.size());
   end

endmodule

// ----- verif/periodic_grain_envelope_gate_tb.sv -----
// Testbench top: clock, reset, stimulus, flow control and the final verdict.
module periodic_grain_envelope_gate_tb;
   import pgeg_pkg::*;

   localparam int SW         = 24;
   localparam int DW         = ((2*SW+7)/8)*8;
   localparam int ITEM_GOAL  = 1600;
   localparam int CYCLE_CAP  = 1000000;
   localparam int HOLD_AT    = 700;
   localparam int HOLD_LEN   = 300;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 4'hF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [DW-1:0]             req_tdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DW-1:0]             rsp_tdata;
   logic [0:0]                rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;

   int fail_count;
   int pending;
   int results_seen;
   int gated_seen;

   int samples_sent = 0;
   int settings_used = 0;
   int burst_left = 0;
   int cycle_count = 0;
   logic hold_rsp = 1'b0;
   int rx_mode = 0;
   int rx_left = 0;
   logic [1:0] rx_phase = '0;

   always #5 clock = ~clock;

   periodic_grain_envelope_gate #(
      .FRAME_RATE (44100),
      .SAMPLE_BITS(SW)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready)
   );

   periodic_grain_envelope_gate_checker #(
      .FRAME_RATE (44100),
      .SAMPLE_BITS(SW)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .fail_count  (fail_count),
      .pending     (pending),
      .results_seen(results_seen),
      .gated_seen  (gated_seen)
   );

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("periodic_grain_envelope_gate verification failed");
         $finish;
      end
   end

   // Result side: a mode is picked for a random stretch of cycles.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_left <= $urandom_range(20, 120);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 1'b1;
      case (rx_mode)
         0:       rsp_tready <= !hold_rsp;
         1:       rsp_tready <= !hold_rsp && (rx_phase != 2'd3);
         2:       rsp_tready <= !hold_rsp && ($urandom_range(0, 1) == 1);
         default: rsp_tready <= !hold_rsp && ($urandom_range(0, 4) == 0);
      endcase
   end

   // One long hold-off on the result side while samples keep coming.
   initial begin
      wait (samples_sent >= HOLD_AT);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Writes one register; the caller lowers csr_valid after the last write.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all four registers, sometimes after a write to an unused index; unused upper data bits carry random junk.
   task automatic program_grain(input logic [LENGTH_BITS-1:0] len,
                                input logic [RATE_BITS-1:0] rate,
                                input logic [RAMP_BITS-1:0] atk,
                                input logic [RAMP_BITS-1:0] dcy);
      if ($urandom_range(0, 3) == 0)
         write_reg(REG_UNUSED, CSR_DATA_BITS'($urandom));
      write_reg(REG_GRAIN_LENGTH, len);
      write_reg(REG_TRIGGER_RATE, {9'($urandom), rate});
      write_reg(REG_ATTACK_LEN, {4'($urandom), atk});
      write_reg(REG_DECAY_LEN, {4'($urandom), dcy});
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Offers one stereo sample and waits for its transaction; then maybe pauses.
   task automatic send_sample(input logic [SW-1:0] l, input logic [SW-1:0] r,
                              input bit last);
      int gap;
      gap = 0;
      req_tdata  <= DW'({r, l});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0:       begin burst_left = $urandom_range(60, 150); gap = 0; end
            1:       begin burst_left = $urandom_range(1, 10);   gap = $urandom_range(30, 70); end
            default: begin burst_left = $urandom_range(1, 20);   gap = $urandom_range(0, 8); end
         endcase
      end
      if (last || gap > 0)
         req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // Waits until every expected result has been taken.
   task automatic drain;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Random sample, with the extremes now and then.
   function automatic logic [SW-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'hFFFFFF;
         default: return SW'($urandom);
      endcase
   endfunction

   function automatic logic [RAMP_BITS-1:0] pick_ramp(input logic [LENGTH_BITS-1:0] len);
      int lim;
      lim = (len < 300) ? int'(len) : 300;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 12'hFFF;
         2:       return RAMP_BITS'($urandom);
         default: return RAMP_BITS'($urandom_range(0, lim));
      endcase
   endfunction

   // Stream of n random samples.
   task automatic send_run(input int n);
      for (int i = 0; i < n; i++)
         send_sample(pick_sample(), pick_sample(), i == n - 1);
   endtask

   // Stimulus and verdict.
   initial begin
      logic [SW-1:0]          edge_vals[5];
      logic [LENGTH_BITS-1:0] len;
      logic [RATE_BITS-1:0]   rate;

      edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short grain with both ramps, fired by the first tick; extreme samples
      // run through the ramps and then through the idle output.
      program_grain(16'd12, 7'd127, 12'd4, 12'd4);
      for (int i = 0; i < 20; i++)
         send_sample(edge_vals[i % 5], edge_vals[(i + 2) % 5], i == 19);
      drain();

      // Longest grain with the widest ramps.
      program_grain(16'hFFFF, 7'd127, 12'hFFF, 12'hFFF);
      send_run(150);
      drain();

      // Length lowered below the running countdown; triggering off.
      program_grain(16'd10, 7'd0, 12'd3, 12'd2);
      send_run(100);
      drain();

      // Zero length: the next trigger silences the grain.
      program_grain(16'd0, 7'd127, 12'd0, 12'd0);
      send_run(100);
      drain();

      // Full frame length with an attack ramp only; the decay ramp is off.
      program_grain(16'd44100, 7'd64, 12'd100, 12'd0);
      send_run(100);
      drain();

      // Random settings, mostly short grains that fire often.
      while (samples_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = 16'd44100;
            2:       len = 16'hFFFF;
            3:       len = LENGTH_BITS'($urandom);
            default: len = LENGTH_BITS'($urandom_range(1, 600));
         endcase
         case ($urandom_range(0, 7))
            0:       rate = '0;
            1:       rate = 7'd127;
            2:       rate = 7'd64;
            default: rate = RATE_BITS'($urandom_range(32, 127));
         endcase
         program_grain(len, rate, pick_ramp(len), pick_ramp(len));
         send_run($urandom_range(60, 260));
         drain();
      end

      repeat (40) @(posedge clock);
      $display("Sent %0d stereo samples under %0d register settings.", samples_sent,
               settings_used);
      $display("Compared %0d results, %0d of them inside a sounding grain.", results_seen,
               gated_seen);
      if (fail_count == 0 && pending == 0)
         $display("periodic_grain_envelope_gate verification clean");
      else
         $display("periodic_grain_envelope_gate verification failed");
      $finish;
   end

endmodule
